>>> sv/conv2d_layer_mac_top_defines.svh
// assertion macros used by the conv2d layer controller rtl (cnv_ctrl)
`ifndef CONV2D_LAYER_MAC_TOP_DEFINES_SVH
`define CONV2D_LAYER_MAC_TOP_DEFINES_SVH
`ifndef SYNTH
`define CNV_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cnv assertion failed");
`define CNV_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cnv assertion failed");
`else
`define CNV_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define CNV_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/cnv_pkg.sv
package cnv_pkg;

  localparam int MAX_SIDE_DEF     = 32;
  localparam int MAX_CHANNELS_DEF = 16;
  localparam int MAX_FILTERS_DEF  = 16;
  localparam int MAX_KERNEL_DEF   = 7;

  localparam int PIX_W      = 16;
  localparam int BIAS_W     = 32;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // register reset values
  localparam logic [5:0] IMAGE_SIDE_RST  = 6'd28;
  localparam logic [4:0] CHANNELS_RST    = 5'd1;
  localparam logic [2:0] KERNEL_SIDE_RST = 3'd3;
  localparam logic [2:0] STEP_RST        = 3'd1;
  localparam logic [1:0] PAD_RST         = 2'd0;

  typedef enum logic [1:0] {
    OP_PIXEL   = 2'd0,
    OP_WEIGHT  = 2'd1,
    OP_BIAS    = 2'd2,
    OP_COMPUTE = 2'd3
  } cnv_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_SIDE  = 3'd0,
    CFG_CHANNELS    = 3'd1,
    CFG_KERNEL_SIDE = 3'd2,
    CFG_STEP        = 3'd3,
    CFG_PAD         = 3'd4
  } cnv_cfg_idx_t;

  typedef struct packed {
    cnv_op_t            op;
    logic [3:0]         filter;
    logic [3:0]         chan;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [31:0] value;
  } cnv_in_t;

  typedef struct packed {
    logic signed [47:0] result;
    logic               status;
  } cnv_out_t;

  typedef struct packed {
    logic [5:0] image_side;
    logic [4:0] channels;
    logic [2:0] kernel_side;
    logic [2:0] step;
    logic [1:0] pad;
  } cnv_cfg_t;

  typedef struct packed {
    logic clear;
    logic tap_valid;
    logic tap_inside;
    logic add_bias;
  } cnv_mac_ctl_t;

endpackage

>>> sv/cnv_mem.sv
module cnv_mem #(
  parameter int DW    = 16,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

endmodule

>>> sv/cnv_mac.sv
module cnv_mac
  import cnv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cnv_mac_ctl_t            ctl,
  input  logic [PIX_W-1:0]        pixel,
  input  logic [PIX_W-1:0]        weight,
  input  logic [BIAS_W-1:0]       bias,
  output logic signed [ACC_W-1:0] acc_r
);

  logic signed [PIX_W-1:0]  pix_s;
  logic signed [PIX_W-1:0]  wgt_s;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic                     prod_v_r;
  logic signed [ACC_W-1:0]  acc_nxt;

  assign pix_s     = pixel;
  assign wgt_s     = weight;
  assign prod_full = pix_s * wgt_s;
  // padding taps contribute nothing
  assign prod_nxt  = ctl.tap_inside ? prod_full : '0;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end else if (ctl.add_bias) begin
      acc_nxt = acc_r + ACC_W'($signed(bias));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.tap_valid;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

>>> sv/cnv_ctrl.sv
`include "conv2d_layer_mac_top_defines.svh"

module cnv_ctrl
  import cnv_pkg::*;
#(
  parameter int MAX_SIDE     = MAX_SIDE_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_FILTERS  = MAX_FILTERS_DEF,
  parameter int MAX_KERNEL   = MAX_KERNEL_DEF,
  localparam int PIX_DEPTH   = MAX_CHANNELS * MAX_SIDE * MAX_SIDE,
  localparam int WGT_DEPTH   = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL,
  localparam int PA_W        = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1,
  localparam int WA_W        = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1,
  localparam int FA_W        = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cnv_cfg_t                cfg,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  cnv_in_t                 in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output cnv_out_t                out_data,
  output logic                    pix_we,
  output logic [PA_W-1:0]         pix_addr,
  output logic                    wgt_we,
  output logic [WA_W-1:0]         wgt_addr,
  output logic                    bias_we,
  output logic [FA_W-1:0]         bias_addr,
  output cnv_mac_ctl_t            mac_ctl,
  input  logic signed [ACC_W-1:0] acc
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_DRAIN,
    S_BIAS,
    S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] filter_r, filter_nxt;
  logic [4:0] row_r, row_nxt;
  logic [4:0] col_r, col_nxt;
  logic [4:0] c_r, c_nxt;
  logic [2:0] kr_r, kr_nxt;
  logic [2:0] kc_r, kc_nxt;
  logic [9:0] rbase_r, rbase_nxt;
  logic [9:0] cbase_r, cbase_nxt;
  logic       drain_r, drain_nxt;
  logic       err_r, err_nxt;
  logic       tap_d1_r;
  logic       inside_d1_r;
  logic       out_valid_r, out_valid_nxt;
  cnv_out_t   out_data_r, out_data_nxt;

  logic       in_acc;
  logic [5:0] side_e;
  logic [4:0] nch_e;
  logic [2:0] ks_e;
  logic [2:0] st_e;
  logic [7:0] row_st;
  logic [7:0] col_st;
  logic [6:0] span;
  logic       row_fit;
  logic       col_fit;
  logic       filt_ok;
  logic [9:0] ir;
  logic [9:0] ic;
  logic       tap_in_image;
  logic [PA_W-1:0] pix_wr_addr, pix_rd_addr;
  logic [WA_W-1:0] wgt_wr_addr, wgt_rd_addr;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // registers beyond the supported range act as the limit
  assign side_e = (cfg.image_side > MAX_SIDE) ? 6'(MAX_SIDE) : cfg.image_side;
  assign nch_e  = (cfg.channels > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : cfg.channels;
  assign ks_e   = (cfg.kernel_side > MAX_KERNEL) ? 3'(MAX_KERNEL) : cfg.kernel_side;
  assign st_e   = (cfg.step == 3'd0) ? 3'd1 : cfg.step;

  // position fits when pos*step + kernel <= image + 2*pad, no divide needed
  assign row_st  = 8'(row_r) * 8'(st_e);
  assign col_st  = 8'(col_r) * 8'(st_e);
  assign span    = 7'(side_e) + 7'({cfg.pad, 1'b0});
  assign row_fit = (9'(row_st) + 9'(ks_e)) <= 9'(span);
  assign col_fit = (9'(col_st) + 9'(ks_e)) <= 9'(span);
  assign filt_ok = (filter_r < MAX_FILTERS);

  assign ir           = rbase_r + 10'(kr_r);
  assign ic           = cbase_r + 10'(kc_r);
  assign tap_in_image = !ir[9] && (ir < 10'(side_e)) && !ic[9] && (ic < 10'(side_e));

  assign pix_wr_addr = PA_W'(in_data.chan) * PA_W'(MAX_SIDE * MAX_SIDE)
                     + PA_W'(in_data.row) * PA_W'(MAX_SIDE) + PA_W'(in_data.col);
  assign pix_rd_addr = PA_W'(c_r) * PA_W'(MAX_SIDE * MAX_SIDE)
                     + PA_W'(ir) * PA_W'(MAX_SIDE) + PA_W'(ic);
  assign wgt_wr_addr = WA_W'(in_data.filter) * WA_W'(MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL)
                     + WA_W'(in_data.chan) * WA_W'(MAX_KERNEL * MAX_KERNEL)
                     + WA_W'(in_data.row) * WA_W'(MAX_KERNEL) + WA_W'(in_data.col);
  assign wgt_rd_addr = WA_W'(filter_r) * WA_W'(MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL)
                     + WA_W'(c_r) * WA_W'(MAX_KERNEL * MAX_KERNEL)
                     + WA_W'(kr_r) * WA_W'(MAX_KERNEL) + WA_W'(kc_r);

  assign pix_addr  = (state_r == S_IDLE) ? pix_wr_addr : pix_rd_addr;
  assign wgt_addr  = (state_r == S_IDLE) ? wgt_wr_addr : wgt_rd_addr;
  assign bias_addr = (state_r == S_IDLE) ? FA_W'(in_data.filter) : FA_W'(filter_r);

  assign pix_we  = in_acc && (in_data.op == OP_PIXEL) && (in_data.chan < MAX_CHANNELS)
                && (in_data.row < MAX_SIDE) && (in_data.col < MAX_SIDE);
  assign wgt_we  = in_acc && (in_data.op == OP_WEIGHT) && (in_data.filter < MAX_FILTERS)
                && (in_data.chan < MAX_CHANNELS) && (in_data.row < MAX_KERNEL)
                && (in_data.col < MAX_KERNEL);
  assign bias_we = in_acc && (in_data.op == OP_BIAS) && (in_data.filter < MAX_FILTERS);

  // read data lands in the cycle after the tap is issued
  assign mac_ctl.clear      = (state_r == S_CHECK);
  assign mac_ctl.tap_valid  = tap_d1_r;
  assign mac_ctl.tap_inside = inside_d1_r;
  assign mac_ctl.add_bias   = (state_r == S_BIAS);

  always_comb begin
    state_nxt     = state_r;
    filter_nxt    = filter_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    c_nxt         = c_r;
    kr_nxt        = kr_r;
    kc_nxt        = kc_r;
    rbase_nxt     = rbase_r;
    cbase_nxt     = cbase_r;
    drain_nxt     = drain_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.op == OP_COMPUTE)) begin
          filter_nxt = in_data.filter;
          row_nxt    = in_data.row;
          col_nxt    = in_data.col;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        drain_nxt = 1'b0;
        if (!filt_ok || !row_fit || !col_fit) begin
          err_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          err_nxt   = 1'b0;
          c_nxt     = '0;
          kr_nxt    = '0;
          kc_nxt    = '0;
          rbase_nxt = 10'(row_st) - 10'(cfg.pad);
          cbase_nxt = 10'(col_st) - 10'(cfg.pad);
          state_nxt = ((nch_e == 5'd0) || (ks_e == 3'd0)) ? S_DRAIN : S_RUN;
        end
      end
      S_RUN: begin
        if (kc_r == ks_e - 3'd1) begin
          kc_nxt = '0;
          if (kr_r == ks_e - 3'd1) begin
            kr_nxt = '0;
            if (c_r == nch_e - 5'd1) begin
              c_nxt     = '0;
              state_nxt = S_DRAIN;
            end else begin
              c_nxt = c_r + 5'd1;
            end
          end else begin
            kr_nxt = kr_r + 3'd1;
          end
        end else begin
          kc_nxt = kc_r + 3'd1;
        end
      end
      S_DRAIN: begin
        // wait here while the read and product stages empty
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = S_BIAS;
        end
      end
      S_BIAS: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.result = err_r ? '0 : acc;
          out_data_nxt.status = err_r;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tap_d1_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tap_d1_r    <= (state_r == S_RUN);
    end
    inside_d1_r <= tap_in_image;
    filter_r    <= filter_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    c_r         <= c_nxt;
    kr_r        <= kr_nxt;
    kc_r        <= kc_nxt;
    rbase_r     <= rbase_nxt;
    cbase_r     <= cbase_nxt;
    drain_r     <= drain_nxt;
    err_r       <= err_nxt;
    out_data_r  <= out_data_nxt;
  end

  `CNV_ASSERT_NXT(a_compute_starts, clk, rst_n, in_acc && (in_data.op == OP_COMPUTE), state_r == S_CHECK)
  `CNV_ASSERT_IMP(a_run_bounds, clk, rst_n, state_r == S_RUN, (kc_r < ks_e) && (kr_r < ks_e) && (c_r < nch_e))
  `CNV_ASSERT_NXT(a_finish_waits, clk, rst_n, (state_r == S_FINISH) && out_valid_r && out_stall, state_r == S_FINISH)
  `CNV_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid_r && out_data_r.status, out_data_r.result == '0)
  `CNV_ASSERT_IMP(a_rise_from_finish, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_FINISH)

endmodule

>>> sv/conv2d_layer_mac_top.sv
// channel  direction  handshake            word
// in_      input      in_valid / in_stall  cnv_in_t: op, filter, chan, row, col, value
// out_     output     out_valid/out_stall  cnv_out_t: result, status
// cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// load words go straight into the stores; a compute word runs over channels * kernel_side^2 taps,
//   fed to the single shared multiply-accumulate that handles one tap per cycle
// a compute word at a position outside the output returns status 1 and a zero result
// synchronous active-low reset; the stores are not cleared, no start-up pass
// a finished result waits in the output register, loads still go through meanwhile
module conv2d_layer_mac_top
  import cnv_pkg::*;
#(
  parameter int MAX_SIDE     = MAX_SIDE_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_FILTERS  = MAX_FILTERS_DEF,
  parameter int MAX_KERNEL   = MAX_KERNEL_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cnv_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cnv_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PIX_DEPTH = MAX_CHANNELS * MAX_SIDE * MAX_SIDE;
  localparam int WGT_DEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int PA_W      = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
  localparam int WA_W      = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int FA_W      = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;

  cnv_cfg_t cfg_r;

  logic                    pix_we, wgt_we, bias_we;
  logic [PA_W-1:0]         pix_addr;
  logic [WA_W-1:0]         wgt_addr;
  logic [FA_W-1:0]         bias_addr;
  logic [PIX_W-1:0]        pix_rdata, wgt_rdata;
  logic [BIAS_W-1:0]       bias_rdata;
  cnv_mac_ctl_t            mac_ctl;
  logic signed [ACC_W-1:0] acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_side  <= IMAGE_SIDE_RST;
      cfg_r.channels    <= CHANNELS_RST;
      cfg_r.kernel_side <= KERNEL_SIDE_RST;
      cfg_r.step        <= STEP_RST;
      cfg_r.pad         <= PAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_SIDE:  cfg_r.image_side  <= cfg_wdata[5:0];
        CFG_CHANNELS:    cfg_r.channels    <= cfg_wdata[4:0];
        CFG_KERNEL_SIDE: cfg_r.kernel_side <= cfg_wdata[2:0];
        CFG_STEP:        cfg_r.step        <= cfg_wdata[2:0];
        CFG_PAD:         cfg_r.pad         <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  cnv_mem #(
    .DW    (PIX_W),
    .DEPTH (PIX_DEPTH)
  ) u_pix_mem (
    .clk     (clk),
    .we      (pix_we),
    .addr    (pix_addr),
    .wdata   (in_data.value[PIX_W-1:0]),
    .rdata_r (pix_rdata)
  );

  cnv_mem #(
    .DW    (PIX_W),
    .DEPTH (WGT_DEPTH)
  ) u_wgt_mem (
    .clk     (clk),
    .we      (wgt_we),
    .addr    (wgt_addr),
    .wdata   (in_data.value[PIX_W-1:0]),
    .rdata_r (wgt_rdata)
  );

  cnv_mem #(
    .DW    (BIAS_W),
    .DEPTH (MAX_FILTERS)
  ) u_bias_mem (
    .clk     (clk),
    .we      (bias_we),
    .addr    (bias_addr),
    .wdata   (in_data.value),
    .rdata_r (bias_rdata)
  );

  cnv_ctrl #(
    .MAX_SIDE     (MAX_SIDE),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_FILTERS  (MAX_FILTERS),
    .MAX_KERNEL   (MAX_KERNEL)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .pix_we    (pix_we),
    .pix_addr  (pix_addr),
    .wgt_we    (wgt_we),
    .wgt_addr  (wgt_addr),
    .bias_we   (bias_we),
    .bias_addr (bias_addr),
    .mac_ctl   (mac_ctl),
    .acc       (acc)
  );

  cnv_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .pixel  (pix_rdata),
    .weight (wgt_rdata),
    .bias   (bias_rdata),
    .acc_r  (acc)
  );

endmodule
